// ----- hw/rtl/kmc_pkg.sv -----
// ----------------------------------------------------------------------------
// kmc_pkg - shared definitions for the 1-D k-means centroid unit
// Sizes, register indexes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package kmc_pkg;

   localparam int CLUSTERS    = 2;
   localparam int STORE_DEPTH = 4096;

   localparam int ADDR_W  = $clog2(STORE_DEPTH);
   localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
   localparam int SAMP_W  = 32;
   localparam int SUM_W   = SAMP_W + CNT_W;
   localparam int DIST_W  = SAMP_W + 1;
   localparam int J_W     = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
   localparam int IDX_W   = 3;
   localparam int LIMIT_W = 10;
   localparam int TOL_W   = 16;
   localparam int DIV_CNT_W = $clog2(SUM_W + 1);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_ITER_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_TOL   = 1'b1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd100;

   // commands from the controller
   typedef struct packed {
      logic           load;
      logic           clear_set;
      logic           div_start;
      logic           div_init;
      logic           init_wr;
      logic           pass_clr;
      logic           scan_rd;
      logic           upd_wr;
      logic           out_load;
      logic           out_last;
      logic [J_W-1:0] jidx;
   } ctrl_cmd_type;

   // status back from the datapath
   typedef struct packed {
      logic scan_done;
      logic pipe_empty;
      logic div_done;
      logic cnt_zero;
      logic changed;
      logic rsp_free;
   } dp_stat_type;

endpackage

// ----- hw/rtl/kmc_div.sv -----
// ----------------------------------------------------------------------------
// kmc_div - sequential floor divider
// Signed dividend over unsigned divisor, one quotient bit per cycle,
// quotient rounded toward minus infinity.
// ----------------------------------------------------------------------------
module kmc_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [kmc_pkg::SUM_W-1:0]   dividend,
   input  logic        [kmc_pkg::CNT_W-1:0]   divisor,
   output logic                               done,
   output logic signed [kmc_pkg::SUM_W-1:0]   quotient
);
   import kmc_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] step_ff;
   logic                 neg_ff;
   logic [SUM_W-1:0]     quo_ff;
   logic [CNT_W-1:0]     rem_ff;
   logic [CNT_W-1:0]     dvs_ff;

   logic [CNT_W:0]       rem_shift;
   logic                 ge;
   logic [CNT_W:0]       rem_in;
   logic [SUM_W-1:0]     mag;

   // one restoring step
   always_comb begin
      rem_shift = {rem_ff, quo_ff[SUM_W-1]};
      ge        = rem_shift >= {1'b0, dvs_ff};
      rem_in    = ge ? (rem_shift - {1'b0, dvs_ff}) : rem_shift;
      mag       = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= DIV_CNT_W'(SUM_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[SUM_W-1];
         quo_ff <= mag;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[SUM_W-2:0], ge};
         rem_ff <= rem_in[CNT_W-1:0];
      end
   end

   // negative with remainder: -(q+1) is ~q
   always_comb begin
      if (neg_ff) begin
         quotient = (rem_ff != '0) ? ~quo_ff : (~quo_ff + 1'b1);
      end else begin
         quotient = quo_ff;
      end
   end

   assign done = done_ff;

endmodule

// ----- hw/rtl/kmc_datapath.sv -----
// ----------------------------------------------------------------------------
// kmc_datapath - sample store, assignment pipeline and centroid update
// Holds the samples, running min/max, centroids, cluster sums and counts,
// the shared divider and the result register.
// ----------------------------------------------------------------------------
module kmc_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  kmc_pkg::ctrl_cmd_type                 cmd,
   output kmc_pkg::dp_stat_type                  stat,
   input  logic signed [kmc_pkg::SAMP_W-1:0]     sample,
   input  logic        [kmc_pkg::TOL_W-1:0]      tol,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic        [kmc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                                  rsp_tlast
);
   import kmc_pkg::*;

   logic signed [SAMP_W-1:0] mem [STORE_DEPTH];

   logic [CNT_W-1:0]         count_ff;
   logic signed [SAMP_W-1:0] min_ff;
   logic signed [SAMP_W-1:0] max_ff;
   logic                     dropped_ff;
   logic signed [SAMP_W-1:0] cent_ff [CLUSTERS];
   logic signed [SUM_W-1:0]  sum_ff  [CLUSTERS];
   logic [CNT_W-1:0]         cnt_ff  [CLUSTERS];
   logic                     changed_ff;
   logic [CNT_W-1:0]         addr_ff;

   // assignment pipeline
   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [SAMP_W-1:0] samp1_ff, samp2_ff, samp3_ff;
   logic [DIST_W-1:0]        dist_ff [CLUSTERS];
   logic [J_W-1:0]           best_ff;

   logic                     rsp_valid_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;
   logic                     rsp_last_ff;

   logic                      full;
   logic [DIST_W-1:0]         bd;
   logic [J_W-1:0]            bi;
   logic [DIST_W:0]           range;
   logic [DIST_W+J_W:0]       prod;
   logic signed [SUM_W-1:0]   div_dividend;
   logic [CNT_W-1:0]          div_divisor;
   logic                      div_done;
   logic signed [SUM_W-1:0]   div_q;
   logic signed [SAMP_W-1:0]  mean;
   logic signed [DIST_W-1:0]  mdiff;
   logic [DIST_W-1:0]         mabs;
   logic                      moved;

   assign full = count_ff == CNT_W'(STORE_DEPTH);

   // nearest centroid, ties to lower index
   always_comb begin
      bd = dist_ff[0];
      bi = '0;
      for (int k = 1; k < CLUSTERS; k++) begin
         if (dist_ff[k] < bd) begin
            bd = dist_ff[k];
            bi = J_W'(k);
         end
      end
   end

   // divider operands: initial spread or cluster mean
   always_comb begin
      range = {{2{max_ff[SAMP_W-1]}}, max_ff} - {{2{min_ff[SAMP_W-1]}}, min_ff};
      prod  = range * {1'b0, cmd.jidx};
      div_dividend = cmd.div_init ? SUM_W'(prod) : sum_ff[cmd.jidx];
      div_divisor  = cmd.div_init ? CNT_W'(CLUSTERS - 1) : cnt_ff[cmd.jidx];
   end

   kmc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // move test of the new mean
   always_comb begin
      mean  = div_q[SAMP_W-1:0];
      mdiff = DIST_W'(mean) - DIST_W'(cent_ff[cmd.jidx]);
      mabs  = mdiff[DIST_W-1] ? (~mdiff + 1'b1) : mdiff;
      moved = mabs > DIST_W'(tol);
   end

   // sample store
   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         mem[count_ff[ADDR_W-1:0]] <= sample;
      end
      if (cmd.scan_rd) begin
         samp1_ff <= mem[addr_ff[ADDR_W-1:0]];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         min_ff       <= {1'b0, {(SAMP_W-1){1'b1}}};
         max_ff       <= {1'b1, {(SAMP_W-1){1'b0}}};
         dropped_ff   <= 1'b0;
         changed_ff   <= 1'b0;
         addr_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < CLUSTERS; k++) begin
            cent_ff[k] <= '0;
            sum_ff[k]  <= '0;
            cnt_ff[k]  <= '0;
         end
      end else begin
         // loading
         if (cmd.load) begin
            if (full) begin
               dropped_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + 1'b1;
               if (sample < min_ff) min_ff <= sample;
               if (sample > max_ff) max_ff <= sample;
            end
         end
         // initial spread
         if (cmd.init_wr) begin
            cent_ff[cmd.jidx] <= min_ff + div_q[SAMP_W-1:0];
         end
         // start of a pass
         if (cmd.pass_clr) begin
            addr_ff    <= '0;
            changed_ff <= 1'b0;
            for (int k = 0; k < CLUSTERS; k++) begin
               sum_ff[k] <= '0;
               cnt_ff[k] <= '0;
            end
         end else if (cmd.scan_rd) begin
            addr_ff <= addr_ff + 1'b1;
         end
         // pipeline valids
         v1_ff <= cmd.scan_rd;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         // accumulate
         if (v3_ff) begin
            sum_ff[best_ff] <= sum_ff[best_ff] + SUM_W'(samp3_ff);
            cnt_ff[best_ff] <= cnt_ff[best_ff] + 1'b1;
         end
         // mean update
         if (cmd.upd_wr && moved) begin
            cent_ff[cmd.jidx] <= mean;
            changed_ff        <= 1'b1;
         end
         // result register
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.clear_set) begin
            count_ff   <= '0;
            min_ff     <= {1'b0, {(SAMP_W-1){1'b1}}};
            max_ff     <= {1'b1, {(SAMP_W-1){1'b0}}};
            dropped_ff <= 1'b0;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      samp2_ff <= samp1_ff;
      for (int k = 0; k < CLUSTERS; k++) begin
         dist_ff[k] <= (samp1_ff >= cent_ff[k])
                       ? (DIST_W'(samp1_ff) - DIST_W'(cent_ff[k]))
                       : (DIST_W'(cent_ff[k]) - DIST_W'(samp1_ff));
      end
      samp3_ff <= samp2_ff;
      best_ff  <= bi;
      if (cmd.out_load) begin
         rsp_data_ff <= {{(RSP_DATA_W-IDX_W-SAMP_W-1){1'b0}}, dropped_ff,
                         cent_ff[cmd.jidx], IDX_W'(cmd.jidx)};
         rsp_last_ff <= cmd.out_last;
      end
   end

   always_comb begin
      stat.scan_done  = addr_ff == count_ff;
      stat.pipe_empty = !v1_ff && !v2_ff && !v3_ff;
      stat.div_done   = div_done;
      stat.cnt_zero   = cnt_ff[cmd.jidx] == '0;
      stat.changed    = changed_ff;
      stat.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- hw/rtl/kmc_ctrl.sv -----
// ----------------------------------------------------------------------------
// kmc_ctrl - sequencing controller
// Loads samples, spreads initial centroids, runs the assign/update passes
// and emits the centroids.
// ----------------------------------------------------------------------------
module kmc_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tlast,
   output logic                             req_tready,
   input  logic [kmc_pkg::LIMIT_W-1:0]      limit,
   input  kmc_pkg::dp_stat_type             stat,
   output kmc_pkg::ctrl_cmd_type            cmd
);
   import kmc_pkg::*;

   typedef enum logic [3:0] {
      ST_LOAD, ST_INIT_DIV, ST_INIT_WAIT, ST_CHECK, ST_SCAN, ST_DRAIN,
      ST_UPD, ST_UPD_WAIT, ST_PASS_END, ST_OUT
   } state_type;

   state_type          state_ff;
   logic [J_W-1:0]     j_ff;
   logic [LIMIT_W-1:0] pass_ff;
   logic               j_last;
   logic               accept;

   assign j_last     = j_ff == J_W'(CLUSTERS - 1);
   assign req_tready = state_ff == ST_LOAD;
   assign accept     = req_tvalid && req_tready;

   // command decode
   always_comb begin
      cmd           = '0;
      cmd.jidx      = j_ff;
      cmd.out_last  = j_last;
      cmd.load      = accept;
      unique case (state_ff)
         ST_INIT_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_init  = 1'b1;
         end
         ST_INIT_WAIT: begin
            cmd.div_init = 1'b1;
            cmd.init_wr  = stat.div_done;
         end
         ST_CHECK:    cmd.pass_clr  = pass_ff < limit;
         ST_SCAN:     cmd.scan_rd   = !stat.scan_done;
         ST_UPD:      cmd.div_start = !stat.cnt_zero;
         ST_UPD_WAIT: cmd.upd_wr    = stat.div_done;
         ST_OUT: begin
            cmd.out_load  = stat.rsp_free;
            cmd.clear_set = stat.rsp_free && j_last;
         end
         default: ;
      endcase
   end

   // state, centroid index and pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         j_ff     <= '0;
         pass_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_LOAD: begin
               if (accept && req_tlast) begin
                  j_ff     <= '0;
                  state_ff <= ST_INIT_DIV;
               end
            end
            ST_INIT_DIV: state_ff <= ST_INIT_WAIT;
            ST_INIT_WAIT: begin
               if (stat.div_done) begin
                  if (j_last) begin
                     state_ff <= ST_CHECK;
                  end else begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= ST_INIT_DIV;
                  end
               end
            end
            ST_CHECK: begin
               j_ff <= '0;
               if (pass_ff < limit) state_ff <= ST_SCAN;
               else                 state_ff <= ST_OUT;
            end
            ST_SCAN: begin
               if (stat.scan_done) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               if (stat.pipe_empty) state_ff <= ST_UPD;
            end
            ST_UPD: begin
               if (!stat.cnt_zero) begin
                  state_ff <= ST_UPD_WAIT;
               end else if (j_last) begin
                  state_ff <= ST_PASS_END;
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
            ST_UPD_WAIT: begin
               if (stat.div_done) begin
                  if (j_last) begin
                     state_ff <= ST_PASS_END;
                  end else begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= ST_UPD;
                  end
               end
            end
            ST_PASS_END: begin
               pass_ff <= pass_ff + 1'b1;
               j_ff    <= '0;
               if (stat.changed) state_ff <= ST_CHECK;
               else              state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (stat.rsp_free) begin
                  if (j_last) begin
                     j_ff     <= '0;
                     pass_ff  <= '0;
                     state_ff <= ST_LOAD;
                  end else begin
                     j_ff <= j_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

endmodule

// ----- hw/rtl/one_dim_kmeans_centroids_unit.sv -----
// Sequence: samples are loaded; after the last sample each initial centroid
// is spread by a division, then each pass scans the samples, drains the
// assignment pipeline and divides each non-empty cluster mean in the shared
// one-bit-per-cycle divider, then CLUSTERS results are streamed. Throughput:
// one sample per cycle while loading; one set at a time. Reset: synchronous,
// active high; clears control state, centroids and settings, not the sample store.
// ----------------------------------------------------------------------------
// one_dim_kmeans_centroids_unit - 1-D k-means centroid unit
// Collects a sample set, runs Lloyd passes and streams the final centroids.
// ----------------------------------------------------------------------------
module one_dim_kmeans_centroids_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_we,
   input  logic [kmc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [kmc_pkg::CSR_DATA_W-1:0]        csr_wdata,
   // samples
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [kmc_pkg::REQ_DATA_W-1:0]        req_tdata,  // [31:0] sample
   input  logic                                  req_tlast,  // last_sample
   // centroids
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [2:0] centroid_index, [34:3] centroid_value, [35] overflow_flag, [39:36] 0
   output logic [kmc_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                  rsp_tlast   // last_centroid
);
   import kmc_pkg::*;

   logic [LIMIT_W-1:0] limit_ff;
   logic [TOL_W-1:0]   tol_ff;
   ctrl_cmd_type       cmd;
   dp_stat_type        stat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         tol_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ITER_LIMIT: limit_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_MOVE_TOL:   tol_ff   <= csr_wdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   kmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .limit      (limit_ff),
      .stat       (stat),
      .cmd        (cmd)
   );

   kmc_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .sample     (req_tdata[SAMP_W-1:0]),
      .tol        (tol_ff),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- tb/sv/kmeans_centroid_checker.sv -----
// ----------------------------------------------------------------------------
// kmeans_centroid_checker - centroid predictor and scoreboard
// Watches the register port and both streams, runs its own Lloyd
// clustering on every closed sample set and compares the centroid stream.
// ----------------------------------------------------------------------------
module kmeans_centroid_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [kmc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [kmc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [kmc_pkg::REQ_DATA_W-1:0]      req_tdata,   // [31:0] sample
   input  logic                                req_tlast,   // last_sample
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [2:0] centroid_index, [34:3] centroid_value, [35] overflow_flag
   input  logic [kmc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                rsp_tlast,   // last_centroid
   output int                                  fail_count,
   output int                                  pending
);
   import kmc_pkg::*;

   typedef struct {
      bit [2:0]  index;
      bit [31:0] value;
      bit        overflow;
      bit        last;
   } centroid_type;

   centroid_type centroid_q[$];
   longint       set_samples[$];
   longint       set_min;
   longint       set_max;
   bit           set_dropped;
   int           iter_limit;
   longint       move_tol;

   function automatic longint mag(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // mean rounded toward minus infinity
   function automatic longint mean_floor(longint s, longint n);
      longint q;
      q = s / n;
      if ((s % n) != 0 && s < 0) q--;
      return q;
   endfunction

   // close the set: spread, Lloyd passes, queue the centroids
   function automatic void cluster_set();
      longint       cen[CLUSTERS];
      longint       sums[CLUSTERS];
      int           cnts[CLUSTERS];
      longint       span, bd, d, m;
      int           best;
      bit           moved;
      centroid_type c;
      span = set_max - set_min;
      for (int j = 0; j < CLUSTERS; j++) cen[j] = set_min + (span * j) / (CLUSTERS - 1);
      for (int p = 0; p < iter_limit; p++) begin
         for (int j = 0; j < CLUSTERS; j++) begin
            sums[j] = 0;
            cnts[j] = 0;
         end
         foreach (set_samples[n]) begin
            best = 0;
            bd   = mag(set_samples[n] - cen[0]);
            for (int j = 1; j < CLUSTERS; j++) begin
               d = mag(set_samples[n] - cen[j]);
               if (d < bd) begin
                  bd   = d;
                  best = j;
               end
            end
            sums[best] += set_samples[n];
            cnts[best]++;
         end
         moved = 0;
         for (int j = 0; j < CLUSTERS; j++) begin
            if (cnts[j] != 0) begin
               m = mean_floor(sums[j], cnts[j]);
               if (mag(m - cen[j]) > move_tol) begin
                  cen[j] = m;
                  moved  = 1;
               end
            end
         end
         if (!moved) break;
      end
      for (int j = 0; j < CLUSTERS; j++) begin
         c.index    = j;
         c.value    = cen[j][31:0];
         c.overflow = set_dropped;
         c.last     = (j == CLUSTERS - 1);
         centroid_q = {centroid_q, c};
      end
      set_samples.delete();
      set_min     = 64'sh7FFFFFFF;
      set_max     = -64'sh80000000;
      set_dropped = 0;
   endfunction

   always @(posedge clock) begin
      centroid_type e;
      if (reset) begin
         centroid_q.delete();
         set_samples.delete();
         set_min     = 64'sh7FFFFFFF;
         set_max     = -64'sh80000000;
         set_dropped = 0;
         iter_limit  = LIMIT_RESET;
         move_tol    = 0;
         fail_count  = 0;
      end else begin
         // register writes
         if (csr_we) begin
            if (csr_index == CSR_ITER_LIMIT) iter_limit = csr_wdata[LIMIT_W-1:0];
            else if (csr_index == CSR_MOVE_TOL) move_tol = csr_wdata[TOL_W-1:0];
         end
         // sample transaction
         if (req_tvalid && req_tready) begin
            if (set_samples.size() < STORE_DEPTH) begin
               set_samples = {set_samples, longint'($signed(req_tdata[31:0]))};
               if (set_samples[$] < set_min) set_min = set_samples[$];
               if (set_samples[$] > set_max) set_max = set_samples[$];
            end else begin
               set_dropped = 1;
            end
            if (req_tlast) cluster_set();
         end
         // centroid transaction
         if (rsp_tvalid && rsp_tready) begin
            if (centroid_q.size() == 0) begin
               $display("%0t: unexpected centroid, actual data=%h last=%b",
                        $time, rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               e = centroid_q.pop_front();
               if (rsp_tdata[2:0] !== e.index) begin
                  $display("%0t: centroid_index expected %0d actual %0d",
                           $time, e.index, rsp_tdata[2:0]);
                  fail_count++;
               end
               if (rsp_tdata[34:3] !== e.value) begin
                  $display("%0t: centroid_value[%0d] expected %h actual %h",
                           $time, e.index, e.value, rsp_tdata[34:3]);
                  fail_count++;
               end
               if (rsp_tdata[35] !== e.overflow) begin
                  $display("%0t: overflow_flag expected %b actual %b",
                           $time, e.overflow, rsp_tdata[35]);
                  fail_count++;
               end
               if (rsp_tlast !== e.last) begin
                  $display("%0t: last_centroid expected %b actual %b",
                           $time, e.last, rsp_tlast);
                  fail_count++;
               end
               if (rsp_tdata[39:36] !== 4'b0) begin
                  $display("%0t: pad bits expected 0 actual %h", $time, rsp_tdata[39:36]);
                  fail_count++;
               end
            end
         end
      end
      pending = centroid_q.size();
   end

endmodule

// ----- tb/sv/tb_one_dim_kmeans_centroids_unit.sv -----
// ----------------------------------------------------------------------------
// tb_one_dim_kmeans_centroids_unit - testbench top for the k-means unit
// Drives sample sets and register settings with bursty input and a stalling
// centroid receiver; the checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_one_dim_kmeans_centroids_unit;
   import kmc_pkg::*;

   localparam int IDLE_LIMIT = 400000;

   logic                    clock = 0;
   logic                    reset = 1;
   logic                    csr_we = 0;
   logic [CSR_IDX_W-1:0]    csr_index = CSR_ITER_LIMIT;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                    req_tvalid = 0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    req_tlast = 0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   int                      fail_count;
   int                      pending;

   int burst_left = 0;
   int samples_sent = 0;
   int hold_reqs = 0;
   int hold_seen = 0;
   int hold_cnt = 0;
   int stall_mode = 0;
   int stall_left = 0;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   one_dim_kmeans_centroids_unit u_dut (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );

   kmeans_centroid_checker u_checker (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .fail_count, .pending
   );

   // centroid receiver: long hold-off on request, otherwise shifting patterns
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_tready <= 0;
      end else if (hold_seen != hold_reqs) begin
         hold_seen = hold_reqs;
         hold_cnt  = 400;
         rsp_tready <= 0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 60);
         end
         stall_left--;
         case (stall_mode)
            0: rsp_tready <= 1;
            1: rsp_tready <= $urandom_range(0, 1);
            default: rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // one sample transaction, with bursts and gaps
   task automatic send_sample(input logic [31:0] value, input logic last, input bit gaps);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (gaps && $urandom_range(0, 3) != 0) begin
            req_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic drop_valid();
      req_tvalid <= 0;
      burst_left = 0;
   endtask

   // wait for all centroids, then let the block settle
   task automatic wait_idle();
      drop_valid();
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      wait_idle();
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we <= 0;
   endtask

   function automatic logic [31:0] pick_sample(input int kind, input logic [31:0] base);
      case (kind)
         0: return $urandom();
         1: return base + $urandom_range(0, 16'hFFFF);
         2: return ($urandom_range(0, 1) ? base : -base) + $urandom_range(0, 255);
         default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      endcase
   endfunction

   // one well-formed set of random content
   task automatic send_random_set(input int count, input bit gaps);
      int          kind;
      logic [31:0] base;
      kind = $urandom_range(0, 9) < 8 ? $urandom_range(0, 2) : 3;
      base = $urandom();
      for (int n = 0; n < count; n++)
         send_sample(pick_sample(kind, base), n == count - 1, gaps);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // extremes of the sample field
      send_sample(32'h8000_0000, 0, 1);
      send_sample(32'h7FFF_FFFF, 1, 1);
      // a set of one sample
      send_sample(32'h0001_8000, 1, 1);
      // equal samples: both centroids start on the same value
      repeat (2) send_sample(32'hFFFF_0000, 0, 1);
      send_sample(32'hFFFF_0000, 1, 1);
      // midpoint sample ties to the lower centroid; negative mean rounds down
      send_sample(32'd0, 0, 1);
      send_sample(32'd10, 0, 1);
      send_sample(32'd5, 1, 1);
      send_sample(-32'sd3, 0, 1);
      send_sample(-32'sd2, 0, 1);
      send_sample(32'd100, 1, 1);

      // zero passes: the spread centroids come out
      write_reg(CSR_ITER_LIMIT, 0);
      send_random_set(4, 1);
      // one pass, widest tolerance
      write_reg(CSR_ITER_LIMIT, 1);
      write_reg(CSR_MOVE_TOL, 16'hFFFF);
      send_random_set(6, 1);
      write_reg(CSR_ITER_LIMIT, 1023);
      write_reg(CSR_MOVE_TOL, 0);
      send_random_set(8, 1);

      // receiver holds off while sets keep coming, so the input stalls
      wait_idle();
      hold_reqs++;
      repeat (3) send_random_set($urandom_range(2, 8), 0);
      wait_idle();

      // random sets with occasional new settings
      while (samples_sent < 360) begin
         if ($urandom_range(0, 5) == 0) begin
            write_reg(CSR_ITER_LIMIT, $urandom_range(0, 3) == 0 ? 1023 : $urandom_range(0, 20));
            write_reg(CSR_MOVE_TOL, $urandom_range(0, 3) == 0 ? $urandom_range(0, 1) * 16'hFFFF
                                                             : $urandom_range(0, 16'hFFFF));
         end
         send_random_set($urandom_range(1, 20), 1);
         if ($urandom_range(0, 4) == 0) wait_idle();
      end

      drop_valid();
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
